/* hw/rtl/slcan_fd_frame_parser_macros.svh */
// Assertion macros for the serial CAN FD frame parser.
// Expects a clock named clk and an active-high reset named rst in the using module.
`ifndef SLCAN_FD_FRAME_PARSER_MACROS_SVH
`define SLCAN_FD_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define SLCANFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLCANFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/slcanfd_pkg.sv */
// Shared types, codes and decode functions of the serial CAN FD frame parser.
// No dependencies.
`default_nettype none

package slcanfd_pkg;

  localparam int OUT_TDATA_W = 40;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ID   = 3'd1;
  localparam logic [2:0] PH_DLC  = 3'd2;
  localparam logic [2:0] PH_HI   = 3'd3;
  localparam logic [2:0] PH_LO   = 3'd4;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  localparam logic [7:0] CHAR_START = 8'h62;

  typedef struct packed {
    logic [2:0]  phase;
    logic [11:0] id;
    logic [6:0]  len;
    logic [5:0]  cnt;
    logic [3:0]  hi;
    logic [1:0]  dc;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] id;
    logic [6:0]  len;
    logic [5:0]  idx;
    logic [7:0]  val;
    logic        last;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase: PH_HUNT, id: 12'd0, len: 7'd0, cnt: 6'd0, hi: 4'd0, dc: 2'd0
  };

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end
    return v;
  endfunction

  function automatic logic [6:0] dlc_len(input logic [3:0] code);
    logic [6:0] n;
    case (code)
      4'd9:    n = 7'd12;
      4'd10:   n = 7'd16;
      4'd11:   n = 7'd20;
      4'd12:   n = 7'd24;
      4'd13:   n = 7'd32;
      4'd14:   n = 7'd48;
      4'd15:   n = 7'd64;
      default: n = {3'b000, code};
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/slcanfd_step.sv */
// Per-character decode step: next parser state and at most one result.
// Depends on slcanfd_pkg.
`default_nettype none

module slcanfd_step #(
  parameter int MAX_DATA_LEN = 64
) (
  input  slcanfd_pkg::state_t  cur,
  input  logic [7:0]           in_char,
  input  logic                 eob,
  output slcanfd_pkg::state_t  nxt,
  output logic                 res_valid,
  output slcanfd_pkg::result_t res
);
  import slcanfd_pkg::*;

  localparam logic [6:0] MAX_LEN = 7'(MAX_DATA_LEN);

  logic [3:0] h;
  logic [6:0] mapped;
  logic [1:0] dc_inc;
  logic [6:0] cnt_inc;
  logic       drop;
  logic       emit;
  logic [1:0] kind;
  logic       last;

  assign h       = hex_val(in_char);
  assign mapped  = dlc_len(h);
  assign dc_inc  = cur.dc + 2'd1;
  assign cnt_inc = 7'(cur.cnt) + 7'd1;

  always_comb begin
    nxt  = cur;
    drop = 1'b0;
    emit = 1'b0;
    kind = KIND_DATA;
    last = 1'b0;
    case (cur.phase)
      PH_ID: begin
        nxt.id = {cur.id[7:0], h};
        nxt.dc = dc_inc;
        if (dc_inc == 2'd3) begin
          nxt.phase = PH_DLC;
        end
        drop = eob;
      end
      PH_DLC: begin
        nxt.len = mapped;
        if (mapped > MAX_LEN) begin
          drop = 1'b1;
        end else if (mapped == 7'd0) begin
          nxt.phase = PH_HUNT;
          emit = 1'b1;
          kind = KIND_EMPTY;
          last = 1'b1;
        end else begin
          nxt.cnt   = 6'd0;
          nxt.phase = PH_HI;
          drop      = eob;
        end
      end
      PH_HI: begin
        nxt.hi    = h;
        nxt.phase = PH_LO;
        drop      = eob;
      end
      PH_LO: begin
        if (cnt_inc >= cur.len) begin
          nxt.phase = PH_HUNT;
          emit = 1'b1;
          last = 1'b1;
        end else if (eob) begin
          drop = 1'b1;
        end else begin
          nxt.cnt   = cnt_inc[5:0];
          nxt.phase = PH_HI;
          emit = 1'b1;
        end
      end
      default: begin
        nxt.phase = PH_HUNT;
        if (in_char == CHAR_START) begin
          nxt       = STATE_RESET;
          nxt.phase = PH_ID;
          drop      = eob;
        end
      end
    endcase
    if (drop) begin
      nxt.phase = PH_HUNT;
    end
  end

  assign res_valid = drop || emit;

  always_comb begin
    res      = '0;
    res.id   = nxt.id;
    res.last = 1'b1;
    if (drop) begin
      res.kind = KIND_DROP;
      res.len  = nxt.len;
      res.idx  = nxt.cnt;
    end else if (kind == KIND_EMPTY) begin
      res.kind = KIND_EMPTY;
    end else begin
      res.kind = KIND_DATA;
      res.len  = cur.len;
      res.idx  = cur.cnt;
      res.val  = {cur.hi, h};
      res.last = last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/slcan_fd_frame_parser.sv */
// Serial CAN FD adapter receive parser: takes one ASCII character per beat, finds
// 'b' frames (three hex digits of identifier, one DLC digit, then hex byte pairs) and
// puts out one beat per data byte, one for a frame without data and one for each
// dropped frame. A character is taken every cycle while s_tready is high. It passes
// an input register and the decode step into the result register, which drives the
// result beat. s_tready falls only while a character that yields a result waits
// behind a result that m_tready has not yet taken. Depends on slcanfd_pkg,
// slcanfd_step and slcan_fd_frame_parser_macros.svh.
`default_nettype none
`include "slcan_fd_frame_parser_macros.svh"

module slcan_fd_frame_parser #(
  parameter int MAX_DATA_LEN = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,  // in_char
  input  logic                                  s_tlast,  // end_of_buffer
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // frame_id[11:0], frame_length[18:12], byte_index[24:19], byte_value[32:25], zero pad
  output logic [slcanfd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic [1:0]                            m_tuser,  // kind
  output logic                                  m_tlast   // frame_last
);
  import slcanfd_pkg::*;

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eob;
  state_t     state;
  logic       out_valid;
  result_t    out_res;

  state_t     step_state;
  logic       step_valid;
  result_t    step_res;
  logic       out_free;
  logic       advance;

  logic       data_beat;
  logic       ctrl_beat;
  logic       empty_beat;
  logic       frame_end;

  slcanfd_step #(
    .MAX_DATA_LEN(MAX_DATA_LEN)
  ) u_step (
    .cur      (state),
    .in_char  (in_char),
    .eob      (in_eob),
    .nxt      (step_state),
    .res_valid(step_valid),
    .res      (step_res)
  );

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && (!step_valid || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      state     <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        state <= step_state;
      end
      if (advance && step_valid) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_eob  <= s_tlast;
    end
    if (advance && step_valid) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.val, out_res.idx, out_res.len, out_res.id};
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;

  assign data_beat  = out_valid && out_res.kind == KIND_DATA;
  assign ctrl_beat  = out_valid && out_res.kind != KIND_DATA;
  assign empty_beat = out_valid && out_res.kind == KIND_EMPTY;
  assign frame_end  = advance && step_valid && step_res.last;

  `SLCANFD_ASSERT_IMP(a_nondata_last, ctrl_beat, out_res.last, "drop or empty beat without last")
  `SLCANFD_ASSERT_IMP(a_index_in_frame, data_beat, 7'(out_res.idx) < out_res.len, "index past length")
  `SLCANFD_ASSERT_IMP(a_empty_zero_len, empty_beat, out_res.len == 7'd0, "empty beat with length")
  `SLCANFD_ASSERT_NEXT(a_last_rehunts, frame_end, state.phase == PH_HUNT, "no hunt after frame end")

endmodule

`default_nettype wire

/* tb/sv/tb_slcan_fd_frame_parser.sv */
// Testbench for slcan_fd_frame_parser: streams ASCII adapter traffic into the parser
// and checks every result beat against a frame-parsing predictor in a scoreboard class.
// Depends on slcanfd_pkg and the slcan_fd_frame_parser RTL.
`default_nettype none

module tb_slcan_fd_frame_parser;
  import slcanfd_pkg::*;

  localparam int MAX_LEN = 64;

  class frame_scoreboard;
    result_t     want_q[$];
    logic [2:0]  phase;
    logic [11:0] id_acc;
    logic [6:0]  len;
    logic [5:0]  cnt;
    logic [3:0]  hi;
    logic [1:0]  dc;
    logic [6:0]  fd_len[7] = '{7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48, 7'd64};
    int          errors;
    int          n_chars;
    int          n_data;
    int          n_empty;
    int          n_drop;

    function new();
      phase = PH_HUNT;
      id_acc = '0;
      len = '0;
      cnt = '0;
      hi = '0;
      dc = '0;
    endfunction

    function logic [3:0] nibble(logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) return c[3:0];
      if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return c[3:0] + 4'd9;
      return 4'd0;
    endfunction

    function logic [6:0] bytes_for_dlc(logic [3:0] code);
      if (code <= 4'd8) return {3'b000, code};
      return fd_len[code - 4'd9];
    endfunction

    function void push(logic [1:0] kind, logic [6:0] l, logic [5:0] idx, logic [7:0] val,
                       logic last);
      result_t r;
      r.kind = kind;
      r.id = id_acc;
      r.len = l;
      r.idx = idx;
      r.val = val;
      r.last = last;
      want_q = {want_q, r};
    endfunction

    function void drop_frame();
      push(KIND_DROP, len, cnt, 8'd0, 1'b1);
      phase = PH_HUNT;
    endfunction

    // returns 1 when the character was taken by the parser rather than skipped
    function bit note_char(logic [7:0] c, bit eob);
      logic [3:0] h;
      logic [7:0] byte_v;
      h = nibble(c);
      n_chars++;
      case (phase)
        PH_ID: begin
          id_acc = {id_acc[7:0], h};
          dc = dc + 2'd1;
          if (dc == 2'd3) phase = PH_DLC;
          if (eob) drop_frame();
        end
        PH_DLC: begin
          len = bytes_for_dlc(h);
          if (len > MAX_LEN) begin
            drop_frame();
          end else if (len == 7'd0) begin
            phase = PH_HUNT;
            push(KIND_EMPTY, 7'd0, 6'd0, 8'd0, 1'b1);
          end else begin
            cnt = '0;
            phase = PH_HI;
            if (eob) drop_frame();
          end
        end
        PH_HI: begin
          hi = h;
          phase = PH_LO;
          if (eob) drop_frame();
        end
        PH_LO: begin
          byte_v = {hi, h};
          if ({1'b0, cnt} + 7'd1 >= len) begin
            phase = PH_HUNT;
            push(KIND_DATA, len, cnt, byte_v, 1'b1);
          end else if (eob) begin
            drop_frame();
          end else begin
            push(KIND_DATA, len, cnt, byte_v, 1'b0);
            cnt = cnt + 6'd1;
            phase = PH_HI;
          end
        end
        default: begin
          phase = PH_HUNT;
          if (c != CHAR_START) return 1'b0;
          id_acc = '0;
          len = '0;
          cnt = '0;
          hi = '0;
          dc = '0;
          phase = PH_ID;
          if (eob) drop_frame();
        end
      endcase
      return 1'b1;
    endfunction

    function void mismatch(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 30) $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      end
    endfunction

    function void check_beat(logic [OUT_TDATA_W-1:0] tdata, logic [1:0] tuser, logic tlast);
      result_t want;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 30) begin
          $display("%0t: beat with nothing expected, expected none got kind %0h tdata %h",
                   $time, tuser, tdata);
        end
        return;
      end
      want = want_q.pop_front();
      mismatch("kind", want.kind, tuser);
      mismatch("frame_id", want.id, tdata[11:0]);
      mismatch("frame_length", want.len, tdata[18:12]);
      mismatch("byte_index", want.idx, tdata[24:19]);
      mismatch("byte_value", want.val, tdata[32:25]);
      mismatch("pad", 32'd0, tdata[OUT_TDATA_W-1:33]);
      mismatch("frame_last", want.last, tlast);
      case (want.kind)
        KIND_DATA:  n_data++;
        KIND_EMPTY: n_empty++;
        default:    n_drop++;
      endcase
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = 8'd0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0]             m_tuser;
  logic                   m_tlast;

  frame_scoreboard sb = new();
  int              burst_left = 0;
  int              used_items = 0;
  int              rdy_cycle = 0;
  int              rdy_mode = 0;

  slcan_fd_frame_parser #(.MAX_DATA_LEN(MAX_LEN)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
      rdy_cycle++;
      if (rdy_cycle % 96 == 0) rdy_mode = $urandom_range(0, 3);
      case (rdy_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= $urandom_range(0, 1);
        2:       m_tready <= ($urandom_range(0, 5) == 0);
        default: m_tready <= (rdy_cycle % 7 < 3);
      endcase
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] rand_digit();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return hex_char(4'($urandom_range(0, 15)));
  endfunction

  task automatic drive_char(input logic [7:0] c, input bit eob);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= eob;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (sb.note_char(c, eob)) used_items++;
  endtask

  task automatic send_text(input string s, input bit eob_on_last);
    for (int i = 0; i < s.len(); i++) drive_char(s[i], eob_on_last && (i == s.len() - 1));
  endtask

  task automatic hold_until_empty();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.want_q.size() != 0);
  endtask

  task automatic send_frame();
    int   code;
    int   total;
    int   cut;
    int   mode;
    bit   eob_end;
    logic [7:0] c;
    code = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    total = 5 + 2 * sb.bytes_for_dlc(4'(code));
    mode = $urandom_range(0, 15);
    cut = (mode <= 4) ? $urandom_range(0, total - 1) : total - 1;
    eob_end = (mode <= 3) || (mode >= 5 && mode <= 8);
    for (int i = 0; i <= cut; i++) begin
      if (i == 0) c = CHAR_START;
      else if (i == 4) c = hex_char(4'(code));
      else c = rand_digit();
      drive_char(c, eob_end && (i == cut));
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(0, 2)) drive_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    int next_hold;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    drive_char(8'h00, 1'b0);
    drive_char(8'hFF, 1'b1);
    send_text("b0000", 1'b0);
    send_text("bFFF1aB", 1'b0);
    drive_char(CHAR_START, 1'b0);
    drive_char(8'hFF, 1'b0);
    send_text("9z20f", 1'b1);
    send_text("b", 1'b1);
    send_text("bab0", 1'b1);
    hold_until_empty();

    next_hold = used_items + 300;
    while (used_items < 900) begin
      if (used_items >= next_hold) begin
        hold_until_empty();
        next_hold = used_items + 300;
      end
      send_noise();
      send_frame();
    end

    hold_until_empty();
    repeat (24) @(posedge clk);
    $display("covered %0d characters (%0d parsed): %0d data beats, %0d empty frames, %0d drops",
             sb.n_chars, used_items, sb.n_data, sb.n_empty, sb.n_drop);
    if (sb.errors == 0) begin
      $display("tb_slcan_fd_frame_parser: clean");
    end else begin
      $display("tb_slcan_fd_frame_parser: errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_slcan_fd_frame_parser: errors");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/slcanfd_pkg.sv
hw/rtl/slcanfd_step.sv
hw/rtl/slcan_fd_frame_parser.sv
tb/sv/tb_slcan_fd_frame_parser.sv
